>>> sv/bully_leader_election_macros.svh
// assertion helpers used by ble_queue
`ifndef BULLY_LEADER_ELECTION_MACROS_SVH
`define BULLY_LEADER_ELECTION_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bully_leader_election: assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bully_leader_election: assertion failed");

`endif

>>> sv/ble_pkg.sv
package ble_pkg;

    localparam int ID_W        = 4;
    localparam int MS_W        = 16;
    localparam int SEQ_W       = 31;
    localparam int TIMER_W     = 32;
    localparam int LAG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FLAGS_W     = 3;

    localparam int MAX_NODES_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [LAG_W-1:0] LAG_MAX = {LAG_W{1'b1}};

    localparam logic [ID_W-1:0]       MY_ID_RST          = 4'd0;
    localparam logic [MS_W-1:0]       BULLY_TIMEOUT_RST  = 16'd1000;
    localparam logic [MS_W-1:0]       SERVER_TIMEOUT_RST = 16'd5;

    // election flag bit positions
    localparam int FLAG_ELECTING = 0;
    localparam int FLAG_BULLIED  = 1;
    localparam int FLAG_TO_LEAD  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MY_ID          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BULLY_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_TIMEOUT = 2'd2;

    typedef enum logic [2:0] {
        FUNC_TICK     = 3'd0,
        FUNC_WORLD    = 3'd1,
        FUNC_ELECTION = 3'd2,
        FUNC_BULLY    = 3'd3,
        FUNC_LEADER   = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_ELECTION   = 3'd1,
        ACT_BULLY      = 3'd2,
        ACT_LEADER_ALL = 3'd3,
        ACT_NEW_SERVER = 3'd4,
        ACT_SELF_LEAD  = 3'd5,
        ACT_WORLD_OK   = 3'd6
    } act_t;

    // everything one input item produces, up to two result words
    typedef struct packed {
        act_t            act0;
        act_t            act1;
        logic            two;
        logic [ID_W-1:0] target;
        logic [ID_W-1:0] leader;
        logic            lost;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> sv/ble_front.sv
module ble_front #(
    parameter int MAX_NODES = ble_pkg::MAX_NODES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ble_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     func,
    input  logic [ble_pkg::MS_W-1:0]       elapsed_ms,
    input  logic [ble_pkg::ID_W-1:0]       sender_id,
    input  logic [ble_pkg::SEQ_W-1:0]      seq_number,
    input  ble_pkg::q_status_t             q_status,
    output logic                           push,
    output ble_pkg::desc_t                 push_desc
);
    import ble_pkg::*;

    localparam int BEST_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W  = ID_W + 1;
    localparam logic [BEST_W-1:0] BEST_RST = BEST_W'(MAX_NODES);

    logic [ID_W-1:0]           my_id_reg;
    logic [MS_W-1:0]           bully_timeout_reg;
    logic [MS_W-1:0]           server_timeout_reg;

    logic [ID_W-1:0]           server_node_reg, server_node_next;
    logic [LAG_W-1:0]          lag_reg, lag_next;
    logic signed [TIMER_W-1:0] no_resp_reg, no_resp_next;
    logic signed [TIMER_W-1:0] bully_wait_reg, bully_wait_next;
    logic signed [TIMER_W-1:0] nack_reg, nack_next;
    logic [BEST_W-1:0]         best_reg, best_next;
    logic [FLAGS_W-1:0]        flags_reg, flags_next;
    logic [SEQ_W-1:0]          last_seq_reg, last_seq_next;

    logic                      accept;
    logic signed [TIMER_W-1:0] bt_load;

    // saturating countdown at the most negative timer value
    function automatic logic signed [TIMER_W-1:0] sat_down(
        input logic signed [TIMER_W-1:0] t,
        input logic [MS_W-1:0]           ms
    );
        logic [TIMER_W:0] diff;
        begin
            diff = {t[TIMER_W-1], t} - {{(TIMER_W+1-MS_W){1'b0}}, ms};
            if (diff[TIMER_W] != diff[TIMER_W-1])
            begin
                sat_down = {1'b1, {(TIMER_W-1){1'b0}}};
            end
            else
            begin
                sat_down = diff[TIMER_W-1:0];
            end
        end
    endfunction

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign bt_load  = {{(TIMER_W-MS_W){1'b0}}, bully_timeout_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_id_reg          <= MY_ID_RST;
            bully_timeout_reg  <= BULLY_TIMEOUT_RST;
            server_timeout_reg <= SERVER_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MY_ID:          my_id_reg          <= cfg_data[ID_W-1:0];
                CFG_BULLY_TIMEOUT:  bully_timeout_reg  <= cfg_data[MS_W-1:0];
                CFG_SERVER_TIMEOUT: server_timeout_reg <= cfg_data[MS_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        logic [LAG_W:0]  lag_sum;
        logic            start;
        logic [1:0]      n;
        logic [CMP_W-1:0] sender_x;
        logic [CMP_W-1:0] best_x;

        server_node_next = server_node_reg;
        lag_next         = lag_reg;
        no_resp_next     = no_resp_reg;
        bully_wait_next  = bully_wait_reg;
        nack_next        = nack_reg;
        best_next        = best_reg;
        flags_next       = flags_reg;
        last_seq_next    = last_seq_reg;

        push_desc        = '0;
        push_desc.act0   = ACT_NONE;
        push_desc.act1   = ACT_NONE;
        n                = 2'd0;
        start            = 1'b0;
        lag_sum          = {1'b0, lag_reg} + {{(LAG_W+1-MS_W){1'b0}}, elapsed_ms};
        sender_x         = {1'b0, sender_id};
        best_x           = CMP_W'(best_reg);

        if (accept)
        begin
            case (func_t'(func))
                FUNC_TICK:
                begin
                    bully_wait_next = sat_down(bully_wait_reg, elapsed_ms);
                    no_resp_next    = sat_down(no_resp_reg, elapsed_ms);
                    nack_next       = sat_down(nack_reg, elapsed_ms);
                    lag_next        = lag_sum[LAG_W] ? LAG_MAX : lag_sum[LAG_W-1:0];
                    start = (lag_next > {1'b0, server_timeout_reg}) &&
                            !flags_reg[FLAG_ELECTING];
                    push_desc.lost = start;
                    if (start)
                    begin
                        flags_next[FLAG_ELECTING] = 1'b1;
                        no_resp_next   = bt_load;
                        best_next      = BEST_RST;
                        push_desc.act0 = ACT_ELECTION;
                        n              = 2'd1;
                    end
                    if (flags_next[FLAG_ELECTING])
                    begin
                        if (!flags_next[FLAG_BULLIED] && !flags_next[FLAG_TO_LEAD] &&
                            (no_resp_next[TIMER_W-1] || no_resp_next == '0))
                        begin
                            if (n == 2'd0) push_desc.act0 = ACT_LEADER_ALL;
                            else           push_desc.act1 = ACT_LEADER_ALL;
                            n = n + 2'd1;
                            nack_next = bt_load;
                            flags_next[FLAG_TO_LEAD] = 1'b1;
                        end
                        else if (flags_next[FLAG_BULLIED] && bully_wait_next[TIMER_W-1])
                        begin
                            if (n == 2'd0) push_desc.act0 = ACT_ELECTION;
                            else           push_desc.act1 = ACT_ELECTION;
                            n = n + 2'd1;
                            no_resp_next = bt_load;
                            best_next    = BEST_RST;
                            flags_next[FLAG_ELECTING] = 1'b1;
                            flags_next[FLAG_BULLIED]  = 1'b0;
                        end
                        else if (flags_next[FLAG_TO_LEAD] && nack_next[TIMER_W-1])
                        begin
                            // to_lead only stands while electing, so no start precedes
                            push_desc.act0 = ACT_LEADER_ALL;
                            push_desc.act1 = ACT_SELF_LEAD;
                            n          = 2'd2;
                            nack_next  = bt_load;
                            flags_next = '0;
                        end
                    end
                end
                FUNC_WORLD:
                begin
                    lag_next = '0;
                    if (sender_id == server_node_reg && seq_number > last_seq_reg)
                    begin
                        last_seq_next  = seq_number;
                        push_desc.act0 = ACT_WORLD_OK;
                        n              = 2'd1;
                    end
                end
                FUNC_ELECTION:
                begin
                    lag_next = '0;
                    if (sender_id > my_id_reg)
                    begin
                        push_desc.act0   = ACT_BULLY;
                        push_desc.act1   = ACT_ELECTION;
                        push_desc.target = sender_id;
                        n                = 2'd2;
                        flags_next[FLAG_ELECTING] = 1'b1;
                        no_resp_next = bt_load;
                        best_next    = BEST_RST;
                    end
                end
                FUNC_BULLY:
                begin
                    lag_next        = '0;
                    bully_wait_next = bt_load;
                    flags_next[FLAG_BULLIED] = 1'b1;
                    flags_next[FLAG_TO_LEAD] = 1'b0;
                end
                FUNC_LEADER:
                begin
                    lag_next = '0;
                    if (sender_id > my_id_reg)
                    begin
                        push_desc.act0   = ACT_BULLY;
                        push_desc.target = sender_id;
                        n                = 2'd1;
                    end
                    else if (sender_x < best_x)
                    begin
                        best_next = BEST_W'(sender_id);
                    end
                    else if (sender_x == best_x)
                    begin
                        flags_next       = '0;
                        server_node_next = sender_id;
                        push_desc.act0   = ACT_NEW_SERVER;
                        push_desc.leader = sender_id;
                        n                = 2'd1;
                    end
                end
                default: ;
            endcase
        end

        push_desc.two = (n == 2'd2);
        push          = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_node_reg <= '0;
            lag_reg         <= '0;
            no_resp_reg     <= '0;
            bully_wait_reg  <= '0;
            nack_reg        <= '0;
            best_reg        <= BEST_RST;
            flags_reg       <= '0;
            last_seq_reg    <= '0;
        end
        else
        begin
            server_node_reg <= server_node_next;
            lag_reg         <= lag_next;
            no_resp_reg     <= no_resp_next;
            bully_wait_reg  <= bully_wait_next;
            nack_reg        <= nack_next;
            best_reg        <= best_next;
            flags_reg       <= flags_next;
            last_seq_reg    <= last_seq_next;
        end
    end

endmodule

>>> sv/ble_queue.sv
`include "bully_leader_election_macros.svh"

module ble_queue #(
    parameter int DEPTH = ble_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ble_pkg::desc_t     push_desc,
    input  logic               pop,
    output ble_pkg::desc_t     head,
    output ble_pkg::q_status_t status
);
    import ble_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t            slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head         = slots_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BLE_ASSERT_NOW(a_no_push_full, push, !status.full)
    `BLE_ASSERT_NOW(a_no_pop_empty, pop, !status.empty)
    `BLE_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `BLE_ASSERT_NOW(a_ptrs_meet, status.empty || status.full, wr_ptr_reg == rd_ptr_reg)

endmodule

>>> sv/ble_back.sv
module ble_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ble_pkg::desc_t           head,
    input  ble_pkg::q_status_t       q_status,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               action,
    output logic [ble_pkg::ID_W-1:0] target_id,
    output logic [ble_pkg::ID_W-1:0] leader_id,
    output logic                     server_lost,
    output logic                     last
);
    import ble_pkg::*;

    logic            valid_reg, valid_next;
    logic            idx_reg, idx_next;
    act_t            act_reg;
    logic [ID_W-1:0] target_reg;
    logic [ID_W-1:0] leader_reg;
    logic            lost_reg;
    logic            last_reg;

    logic            load;
    logic            fire;
    act_t            cur_act;
    logic            cur_last;

    assign load     = !valid_reg || out_ready;
    assign fire     = load && !q_status.empty;
    assign cur_act  = idx_reg ? head.act1 : head.act0;
    assign cur_last = !(head.two && !idx_reg);
    // head leaves the queue with its final word
    assign pop      = fire && cur_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = !q_status.empty;
        end
        if (fire)
        begin
            idx_next = !cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            act_reg    <= cur_act;
            target_reg <= (cur_act == ACT_BULLY) ? head.target : '0;
            leader_reg <= (cur_act == ACT_NEW_SERVER) ? head.leader : '0;
            lost_reg   <= head.lost;
            last_reg   <= cur_last;
        end
    end

    assign out_valid   = valid_reg;
    assign action      = act_reg;
    assign target_id   = target_reg;
    assign leader_id   = leader_reg;
    assign server_lost = lost_reg;
    assign last        = last_reg;

endmodule

>>> sv/bully_leader_election.sv
// channel   direction  handshake             words
// cfg       in         cfg_we                cfg_index, cfg_data
// in        in         in_valid / in_ready   func, elapsed_ms, sender_id, seq_number
// out       out        out_valid / out_ready action, target_id, leader_id, server_lost, last
//
// one input word accepted per cycle while the event queue has room; state updates
// in the cycle of acceptance, so a word's effect is seen by the very next word
// each input word yields zero, one or two result words; the output register drains
// one result per cycle while out_ready is high, so a two-result word gives its results in turn
// first result goes from the queue slot written at the accepting edge to the output
// register, which loads when it is empty or out_ready is high
// reset returns config to its defaults and resets election state, timers and the
// queue; out_ready low fills the QUEUE_DEPTH-entry queue and then drops in_ready
module bully_leader_election #(
    parameter int MAX_NODES   = ble_pkg::MAX_NODES_DEF,
    parameter int QUEUE_DEPTH = ble_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ble_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     func,
    input  logic [ble_pkg::MS_W-1:0]       elapsed_ms,
    input  logic [ble_pkg::ID_W-1:0]       sender_id,
    input  logic [ble_pkg::SEQ_W-1:0]      seq_number,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     action,
    output logic [ble_pkg::ID_W-1:0]       target_id,
    output logic [ble_pkg::ID_W-1:0]       leader_id,
    output logic                           server_lost,
    output logic                           last
);
    import ble_pkg::*;

    q_status_t q_status;
    logic      push;
    logic      pop;
    desc_t     push_desc;
    desc_t     head;

    ble_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .elapsed_ms (elapsed_ms),
        .sender_id  (sender_id),
        .seq_number (seq_number),
        .q_status   (q_status),
        .push       (push),
        .push_desc  (push_desc)
    );

    ble_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    ble_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .action      (action),
        .target_id   (target_id),
        .leader_id   (leader_id),
        .server_lost (server_lost),
        .last        (last)
    );

endmodule

>>> tb/sv/tb.sv
module tb;
    import ble_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam longint TIMER_FLOOR = -64'sd2147483648;

    typedef struct packed {
        act_t            act;
        logic [ID_W-1:0] target;
        logic [ID_W-1:0] leader;
        logic            lost;
        logic            last;
    } result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            func;
    logic [MS_W-1:0]       elapsed_ms;
    logic [ID_W-1:0]       sender_id;
    logic [SEQ_W-1:0]      seq_number;
    logic                  out_valid;
    logic                  out_ready;
    logic [2:0]            action;
    logic [ID_W-1:0]       target_id;
    logic [ID_W-1:0]       leader_id;
    logic                  server_lost;
    logic                  last;

    // node state as the election logic should hold it
    logic [ID_W-1:0]  node_id;
    logic [MS_W-1:0]  elect_timeout;
    logic [MS_W-1:0]  lag_limit;
    logic [ID_W-1:0]  server_id;
    logic [LAG_W-1:0] lag_ms;
    longint           reply_wait;
    longint           bullied_wait;
    longint           nack_wait;
    logic [4:0]       best_id;
    logic             electing;
    logic             bullied;
    logic             to_lead;
    logic [SEQ_W-1:0] last_seq;

    result_t pending_actions[$];
    result_t want;
    int      mismatches = 0;
    int      words_sent = 0;
    int      stall_cycles;
    int      hold_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    bully_leader_election dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint count_down(longint t, logic [MS_W-1:0] ms);
        longint r;
        r = t - longint'(ms);
        return (r < TIMER_FLOOR) ? TIMER_FLOOR : r;
    endfunction

    function automatic void push_action(act_t a, logic [ID_W-1:0] tgt,
                                        logic [ID_W-1:0] ldr, logic lost);
        result_t r;
        r.act    = a;
        r.target = tgt;
        r.leader = ldr;
        r.lost   = lost;
        r.last   = 1'b0;
        pending_actions.push_back(r);
    endfunction

    function automatic void open_election(logic lost);
        electing   = 1'b1;
        reply_wait = longint'(elect_timeout);
        best_id    = 5'(MAX_NODES_DEF);
        push_action(ACT_ELECTION, '0, '0, lost);
    endfunction

    function automatic void predict_actions(logic [2:0] fn, logic [MS_W-1:0] ms,
                                            logic [ID_W-1:0] sid, logic [SEQ_W-1:0] seq);
        int   prior_count;
        int   lag_sum;
        logic lost;
        prior_count = pending_actions.size();
        lost        = 1'b0;
        if (fn == FUNC_TICK)
        begin
            bullied_wait = count_down(bullied_wait, ms);
            reply_wait   = count_down(reply_wait, ms);
            nack_wait    = count_down(nack_wait, ms);
            lag_sum = int'(lag_ms) + int'(ms);
            if (lag_sum > int'(LAG_MAX))
                lag_ms = LAG_MAX;
            else
                lag_ms = LAG_W'(lag_sum);
            if (lag_ms > lag_limit && !electing)
            begin
                lost = 1'b1;
                open_election(lost);
            end
            if (electing)
            begin
                if (!bullied && !to_lead && reply_wait <= 0)
                begin
                    push_action(ACT_LEADER_ALL, '0, '0, lost);
                    nack_wait = longint'(elect_timeout);
                    to_lead   = 1'b1;
                end
                else if (bullied && bullied_wait < 0)
                begin
                    open_election(lost);
                    bullied = 1'b0;
                end
                else if (to_lead && nack_wait < 0)
                begin
                    push_action(ACT_LEADER_ALL, '0, '0, lost);
                    nack_wait = longint'(elect_timeout);
                    push_action(ACT_SELF_LEAD, '0, '0, lost);
                    electing = 1'b0;
                    bullied  = 1'b0;
                    to_lead  = 1'b0;
                end
            end
        end
        else if (fn <= FUNC_LEADER)
        begin
            lag_ms = '0;
            if (fn == FUNC_WORLD)
            begin
                if (sid == server_id && seq > last_seq)
                begin
                    last_seq = seq;
                    push_action(ACT_WORLD_OK, '0, '0, 1'b0);
                end
            end
            else if (fn == FUNC_ELECTION)
            begin
                if (sid > node_id)
                begin
                    push_action(ACT_BULLY, sid, '0, 1'b0);
                    open_election(1'b0);
                end
            end
            else if (fn == FUNC_BULLY)
            begin
                bullied_wait = longint'(elect_timeout);
                bullied      = 1'b1;
                to_lead      = 1'b0;
            end
            else
            begin
                if (sid > node_id)
                    push_action(ACT_BULLY, sid, '0, 1'b0);
                else if ({1'b0, sid} < best_id)
                    best_id = {1'b0, sid};
                else if ({1'b0, sid} == best_id)
                begin
                    electing  = 1'b0;
                    bullied   = 1'b0;
                    to_lead   = 1'b0;
                    server_id = sid;
                    push_action(ACT_NEW_SERVER, '0, sid, 1'b0);
                end
            end
        end
        if (pending_actions.size() > prior_count)
            pending_actions[pending_actions.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [MS_W-1:0] clamp_ms(int v);
        return (v > 65535) ? 16'hFFFF : MS_W'(v);
    endfunction

    task automatic send_word(logic [2:0] fn, logic [MS_W-1:0] ms,
                             logic [ID_W-1:0] sid, logic [SEQ_W-1:0] seq);
        @(negedge clk);
        // each idle cycle is drawn on its own
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= fn;
        elapsed_ms <= ms;
        sender_id  <= sid;
        seq_number <= seq;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_actions(fn, ms, sid, seq);
        if (fn <= FUNC_LEADER)
            words_sent++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MY_ID)
            node_id = data[ID_W-1:0];
        else if (idx == CFG_BULLY_TIMEOUT)
            elect_timeout = data;
        else if (idx == CFG_SERVER_TIMEOUT)
            lag_limit = data;
    endtask

    task automatic set_config(logic [ID_W-1:0] id, logic [MS_W-1:0] bto, logic [MS_W-1:0] sto);
        // upper bits of the id write are don't-care
        write_reg(CFG_MY_ID, {12'($urandom), id});
        write_reg(CFG_BULLY_TIMEOUT, bto);
        write_reg(CFG_SERVER_TIMEOUT, sto);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic run_traffic(int n_words);
        int               start;
        int               pick;
        int               v;
        int               k;
        logic [ID_W-1:0]  s;
        logic [SEQ_W-1:0] q;
        start = words_sent;
        while (words_sent - start < n_words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                case ($urandom_range(0, 4))
                    0:       v = $urandom_range(0, 3);
                    1:       v = $urandom_range(0, int'(elect_timeout) + 1);
                    2:       v = int'(lag_limit) + 1;
                    3:       v = $urandom_range(0, 65535);
                    default: v = 65535;
                endcase
                send_word(FUNC_TICK, clamp_ms(v), 4'($urandom), 31'($urandom));
            end
            else if (pick < 35)
            begin
                // lose the server, announce, then take over
                send_word(FUNC_TICK, clamp_ms(int'(lag_limit) + 1), 4'($urandom), 31'($urandom));
                send_word(FUNC_TICK, elect_timeout, 4'($urandom), 31'($urandom));
                send_word(FUNC_TICK, clamp_ms(int'(elect_timeout) + 1), 4'($urandom),
                          31'($urandom));
            end
            else if (pick < 45)
                send_word(FUNC_ELECTION, 16'($urandom), 4'($urandom), 31'($urandom));
            else if (pick < 52)
                send_word(FUNC_BULLY, 16'($urandom), 4'($urandom), 31'($urandom));
            else if (pick < 64)
            begin
                // a node at or below this one claims leadership twice, then streams world words
                s = $urandom_range(0, node_id);
                send_word(FUNC_LEADER, 16'($urandom), s, 31'($urandom));
                send_word(FUNC_LEADER, 16'($urandom), s, 31'($urandom));
                k = $urandom_range(0, 3);
                repeat (k)
                begin
                    q = last_seq + 31'($urandom_range(1, 50));
                    send_word(FUNC_WORLD, 16'($urandom), s, q);
                end
            end
            else if (pick < 74)
            begin
                q = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                : last_seq + 31'($urandom_range(0, 50));
                send_word(FUNC_WORLD, 16'($urandom), server_id, q);
            end
            else if (pick < 84)
                send_word(FUNC_LEADER, 16'($urandom), 4'($urandom), 31'($urandom));
            else if (pick < 94)
                send_word(FUNC_WORLD, 16'($urandom), 4'($urandom), 31'($urandom));
            else
                send_word(3'($urandom_range(5, 7)), 16'($urandom), 4'($urandom),
                          31'($urandom));
        end
        wait_idle();
    endtask

    task automatic test_directed();
        set_idling(28, 77);
        // reset settings: id 0, bully timeout 1000, server timeout 5
        send_word(FUNC_TICK, 16'd0, 4'd0, 31'd0);
        send_word(FUNC_TICK, 16'd6, 4'd15, 31'h7FFFFFFF);
        send_word(FUNC_ELECTION, 16'hFFFF, 4'd15, 31'd0);
        send_word(FUNC_ELECTION, 16'd0, 4'd0, 31'd0);
        send_word(FUNC_TICK, 16'd1000, 4'd0, 31'd0);
        send_word(FUNC_TICK, 16'd1001, 4'd0, 31'd0);
        send_word(FUNC_TICK, 16'hFFFF, 4'd0, 31'd0);
        send_word(FUNC_TICK, 16'hFFFF, 4'd0, 31'd0);
        send_word(FUNC_BULLY, 16'd0, 4'd15, 31'd0);
        send_word(FUNC_TICK, 16'd1001, 4'd0, 31'd0);
        send_word(FUNC_WORLD, 16'd0, 4'd0, 31'h7FFFFFFF);
        send_word(FUNC_WORLD, 16'd0, 4'd0, 31'h7FFFFFFF);
        send_word(FUNC_WORLD, 16'd0, 4'd3, 31'h7FFFFFFF);
        send_word(FUNC_LEADER, 16'd0, 4'd0, 31'd0);
        send_word(FUNC_LEADER, 16'd0, 4'd0, 31'd0);
        send_word(3'd5, 16'hFFFF, 4'd15, 31'h7FFFFFFF);
        send_word(3'd6, 16'hFFFF, 4'd15, 31'h7FFFFFFF);
        send_word(3'd7, 16'hFFFF, 4'd15, 31'h7FFFFFFF);
        send_word(FUNC_LEADER, 16'd0, 4'd15, 31'd0);
        send_word(FUNC_TICK, 16'd0, 4'd0, 31'h2AAAAAAA);
        send_word(FUNC_WORLD, 16'h5555, 4'd0, 31'd1);
        wait_idle();
    endtask

    task automatic test_low_extremes();
        set_idling(28, 77);
        set_config(4'd0, 16'd1, 16'd0);
        run_traffic(200);
    endtask

    task automatic test_high_extremes();
        set_idling(77, 28);
        set_config(4'd15, 16'hFFFF, 16'hFFFF);
        run_traffic(200);
    endtask

    task automatic test_random_traffic();
        int mode;
        for (mode = 0; mode < 3; mode++)
        begin
            if (mode == 0)
                set_idling(28, 77);
            else if (mode == 1)
                set_idling(77, 28);
            else
                set_idling(0, 0);
            repeat (2)
            begin
                case ($urandom_range(0, 2))
                    0:       set_config(4'($urandom), 16'($urandom_range(1, 20)),
                                        16'($urandom_range(0, 20)));
                    1:       set_config(4'($urandom), 16'($urandom_range(1, 2000)),
                                        16'($urandom_range(0, 2000)));
                    default: set_config(4'($urandom), 16'($urandom_range(1, 65535)),
                                        16'($urandom));
                endcase
                run_traffic(150);
            end
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        set_config(4'd3, 16'd500, 16'd100);
        // receiver stalls long enough for the queue to fill and block input
        hold_cycles = 150;
        repeat (30)
            send_word(FUNC_ELECTION, 16'($urandom), 4'($urandom_range(4, 15)), 31'($urandom));
        wait_idle();
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_actions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 200)
                    $display("%0t: unexpected word: action=%0d target=%0d leader=%0d lost=%0d last=%0d",
                             $time, action, target_id, leader_id, server_lost, last);
            end
            else
            begin
                want = pending_actions.pop_front();
                if (action !== want.act || target_id !== want.target ||
                    leader_id !== want.leader || server_lost !== want.lost ||
                    last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 200)
                        $display("%0t: mismatch: expected action=%0d target=%0d leader=%0d lost=%0d last=%0d, got action=%0d target=%0d leader=%0d lost=%0d last=%0d",
                                 $time, want.act, want.target, want.leader, want.lost,
                                 want.last, action, target_id, leader_id, server_lost, last);
                end
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        func       = '0;
        elapsed_ms = '0;
        sender_id  = '0;
        seq_number = '0;

        node_id       = MY_ID_RST;
        elect_timeout = BULLY_TIMEOUT_RST;
        lag_limit     = SERVER_TIMEOUT_RST;
        server_id     = '0;
        lag_ms        = '0;
        reply_wait    = 0;
        bullied_wait  = 0;
        nack_wait     = 0;
        best_id       = 5'(MAX_NODES_DEF);
        electing      = 1'b0;
        bullied       = 1'b0;
        to_lead       = 1'b0;
        last_seq      = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_low_extremes();
        test_high_extremes();
        test_random_traffic();
        test_backpressure();

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
